@@ hw/rtl/acpq_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis cylinder point query package
// Shared constants, codes and stage types of the cylinder query pipeline.
// ----------------------------------------------------------------------------
package acpq_pkg;

  // Default width of the significant coordinate bits.
  localparam int unsigned CRD_WIDTH = 32;

  // Scale between the tolerance register and the surface band.
  localparam int unsigned TOL_SCALE = 100;

  // Bits of the integer square root and of one normal magnitude.
  localparam int unsigned ROOT_BITS = 34;
  localparam int unsigned NORM_BITS = 15;

  // Width of the normal unit's residual and step accumulators.
  localparam int unsigned ACC_W = 104;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_AXIS   = 3'd0,
    REG_CTR1   = 3'd1,
    REG_CTR2   = 3'd2,
    REG_RADIUS = 3'd3,
    REG_SENSE  = 3'd4,
    REG_TOL    = 3'd5
  } reg_idx_e;

  // Cylinder axis codes; the unused code behaves as the z axis.
  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Point classification codes.
  typedef enum logic [1:0] {
    CLS_INSIDE  = 2'd0,
    CLS_OUTSIDE = 2'd1,
    CLS_SURFACE = 2'd2
  } cls_e;

  // Transverse offsets and directions.
  typedef struct packed {
    logic signed [32:0] d1;
    logic signed [32:0] d2;
    logic signed [31:0] v1;
    logic signed [31:0] v2;
  } s0_t;

  // Raw products.
  typedef struct packed {
    logic [64:0]        d1sq;
    logic [64:0]        d2sq;
    logic [62:0]        v1sq;
    logic [62:0]        v2sq;
    logic signed [64:0] dv1;
    logic signed [64:0] dv2;
    logic [61:0]        rsq;
    logic [38:0]        thr;
    logic               neg1;
    logic               neg2;
    logic               z1;
    logic               z2;
  } s1_t;

  // Quadric sums.
  typedef struct packed {
    logic [65:0]        sq;
    logic signed [66:0] c;
    logic [63:0]        a;
    logic signed [66:0] b;
    logic [38:0]        thr;
    logic [64:0]        d1sq;
    logic [64:0]        d2sq;
    logic               neg1;
    logic               neg2;
    logic               z1;
    logic               z2;
  } s2_t;

  // State of one root and normal iteration stage.
  typedef struct packed {
    cls_e                   cls;
    logic [62:0]            a_sat;
    logic [63:0]            b_sat;
    logic [63:0]            c_sat;
    logic [65:0]            rem;
    logic [ROOT_BITS-1:0]   root;
    logic [65:0]            s;
    logic signed [ACC_W-1:0] e1;
    logic signed [ACC_W-1:0] p1;
    logic signed [ACC_W-1:0] e2;
    logic signed [ACC_W-1:0] p2;
    logic [NORM_BITS-1:0]   q1;
    logic [NORM_BITS-1:0]   q2;
    logic                   neg1;
    logic                   neg2;
    logic                   z1;
    logic                   z2;
  } it_t;

  // One finished result.
  typedef struct packed {
    cls_e               cls;
    logic signed [31:0] sdist;
    logic [62:0]        a;
    logic [63:0]        b;
    logic [63:0]        c;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } res_t;

  // Saturate a 67-bit signed value to 64 bits.
  function automatic logic [63:0] sat64(input logic signed [66:0] v);
    logic [63:0] r;
    if ((v[66:63] == 4'b0000) || (v[66:63] == 4'b1111)) begin
      r = v[63:0];
    end else if (v[66]) begin
      r = 64'h8000_0000_0000_0000;
    end else begin
      r = 64'h7FFF_FFFF_FFFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ hw/rtl/axis_cylinder_point_query.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis cylinder point query
// Classifies a point against an axis-parallel cylinder and returns the ray
// quadratic, the radial distance and the unit surface normal.
// ----------------------------------------------------------------------------
// Usage:
// - Requests enter on in_valid_i with the point and direction fields; a
//   request is taken at a clock edge where in_valid_i is high and
//   in_stall_o is low. Results leave on out_valid_o, one per request, in
//   order, and are taken when out_stall_i is low.
// - The cylinder is set through the write port (cfg_we_i, cfg_index_i,
//   cfg_wdata_i) while no request is in flight.
// - Throughput is one request per cycle while in_stall_o is low. A request
//   passes four stages of offsets, products, sums and classification,
//   then 34 stages of the bit-per-stage square root, whose first 15 stages
//   also run the two normal division lanes, then the output register.
// - When the receiver stalls, the output register holds its result and one
//   more result lands in a skid register; only then does in_stall_o rise
//   and the whole pipeline hold.
// - Reset clears all valid bits and loads the default cylinder: z axis,
//   center zero, radius 65536, sense +1, tolerance 429.
// ----------------------------------------------------------------------------
module axis_cylinder_point_query #(
  parameter int unsigned COORD_WIDTH = acpq_pkg::CRD_WIDTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [31:0]        cfg_wdata_i,
  // Request channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic signed [31:0] dir_x_i,
  input  logic signed [31:0] dir_y_i,
  input  logic signed [31:0] dir_z_i,
  // Result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [1:0]         inside_class_o,
  output logic signed [31:0] signed_distance_o,
  output logic [62:0]        quad_a_o,
  output logic signed [63:0] quad_b_o,
  output logic signed [63:0] quad_c_o,
  output logic signed [15:0] normal_x_o,
  output logic signed [15:0] normal_y_o,
  output logic signed [15:0] normal_z_o
);

  localparam int unsigned SH = 32 - COORD_WIDTH;
  localparam int unsigned RB = acpq_pkg::ROOT_BITS;
  localparam int unsigned NB = acpq_pkg::NORM_BITS;
  localparam int unsigned AW = acpq_pkg::ACC_W;

  // Sign-extend a coordinate from its significant bits.
  function automatic logic signed [31:0] sext(input logic [31:0] x);
    logic signed [31:0] t;
    t = $signed(x << SH);
    return t >>> SH;
  endfunction

  // Configuration registers.
  logic [1:0]  axis_q;
  logic [31:0] ctr1_q;
  logic [31:0] ctr2_q;
  logic [30:0] radius_q;
  logic        sense_q;
  logic [31:0] tol_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_q   <= acpq_pkg::AXIS_Z;
      ctr1_q   <= '0;
      ctr2_q   <= '0;
      radius_q <= 31'd65536;
      sense_q  <= 1'b1;
      tol_q    <= 32'd429;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        acpq_pkg::REG_AXIS:   axis_q   <= cfg_wdata_i[1:0];
        acpq_pkg::REG_CTR1:   ctr1_q   <= cfg_wdata_i;
        acpq_pkg::REG_CTR2:   ctr2_q   <= cfg_wdata_i;
        acpq_pkg::REG_RADIUS: radius_q <= cfg_wdata_i[30:0];
        acpq_pkg::REG_SENSE:  sense_q  <= cfg_wdata_i[0];
        acpq_pkg::REG_TOL:    tol_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Pipeline advance: everything moves unless the skid register is full.
  logic skid_valid_q;
  logic en;
  assign en         = ~skid_valid_q;
  assign in_stall_o = skid_valid_q;

  // Stage 0: pick the transverse coordinates and subtract the center.
  logic signed [31:0] p1, p2, v1, v2;
  acpq_pkg::s0_t      s0_d, s0_q;
  logic               s0_v_q;

  always_comb begin
    case (axis_q)
      acpq_pkg::AXIS_X: begin
        p1 = sext(point_y_i); p2 = sext(point_z_i);
        v1 = sext(dir_y_i);   v2 = sext(dir_z_i);
      end
      acpq_pkg::AXIS_Y: begin
        p1 = sext(point_x_i); p2 = sext(point_z_i);
        v1 = sext(dir_x_i);   v2 = sext(dir_z_i);
      end
      default: begin
        p1 = sext(point_x_i); p2 = sext(point_y_i);
        v1 = sext(dir_x_i);   v2 = sext(dir_y_i);
      end
    endcase
    s0_d.d1 = 33'(p1) - 33'(sext(ctr1_q));
    s0_d.d2 = 33'(p2) - 33'(sext(ctr2_q));
    s0_d.v1 = v1;
    s0_d.v2 = v2;
  end

  // Stage 1: all products, one multiplier each.
  acpq_pkg::s1_t      s1_d, s1_q;
  logic               s1_v_q;
  logic signed [65:0] m_d1, m_d2, m_dv1, m_dv2;
  logic signed [63:0] m_v1, m_v2;

  always_comb begin
    m_d1  = s0_q.d1 * s0_q.d1;
    m_d2  = s0_q.d2 * s0_q.d2;
    m_v1  = s0_q.v1 * s0_q.v1;
    m_v2  = s0_q.v2 * s0_q.v2;
    m_dv1 = s0_q.d1 * s0_q.v1;
    m_dv2 = s0_q.d2 * s0_q.v2;
    s1_d.d1sq = m_d1[64:0];
    s1_d.d2sq = m_d2[64:0];
    s1_d.v1sq = m_v1[62:0];
    s1_d.v2sq = m_v2[62:0];
    s1_d.dv1  = m_dv1[64:0];
    s1_d.dv2  = m_dv2[64:0];
    s1_d.rsq  = radius_q * radius_q;
    s1_d.thr  = 39'(tol_q) * 39'(acpq_pkg::TOL_SCALE);
    s1_d.neg1 = s0_q.d1[32];
    s1_d.neg2 = s0_q.d2[32];
    s1_d.z1   = (s0_q.d1 == '0);
    s1_d.z2   = (s0_q.d2 == '0);
  end

  // Stage 2: quadric sums.
  acpq_pkg::s2_t s2_d, s2_q;
  logic          s2_v_q;

  always_comb begin
    s2_d.sq   = 66'(s1_q.d1sq) + 66'(s1_q.d2sq);
    s2_d.c    = $signed({1'b0, s2_d.sq}) - $signed({5'b0, s1_q.rsq});
    s2_d.a    = 64'(s1_q.v1sq) + 64'(s1_q.v2sq);
    s2_d.b    = (67'(s1_q.dv1) + 67'(s1_q.dv2)) <<< 1;
    s2_d.thr  = s1_q.thr;
    s2_d.d1sq = s1_q.d1sq;
    s2_d.d2sq = s1_q.d2sq;
    s2_d.neg1 = s1_q.neg1;
    s2_d.neg2 = s1_q.neg2;
    s2_d.z1   = s1_q.z1;
    s2_d.z2   = s1_q.z2;
  end

  // Stage 3: classify, saturate and seed the root and normal units.
  acpq_pkg::it_t      it_q [RB+1];
  logic               it_v_q [RB+1];
  acpq_pkg::it_t      it0_d;
  logic signed [67:0] sv;
  logic signed [67:0] thr_s;

  always_comb begin
    sv    = sense_q ? 68'(s2_q.c) : -68'(s2_q.c);
    thr_s = $signed({29'b0, s2_q.thr});
    if (sv > thr_s) begin
      it0_d.cls = acpq_pkg::CLS_INSIDE;
    end else if (sv < -thr_s) begin
      it0_d.cls = acpq_pkg::CLS_OUTSIDE;
    end else begin
      it0_d.cls = acpq_pkg::CLS_SURFACE;
    end
    it0_d.a_sat = s2_q.a[63] ? {63{1'b1}} : s2_q.a[62:0];
    it0_d.b_sat = acpq_pkg::sat64(s2_q.b);
    it0_d.c_sat = acpq_pkg::sat64(s2_q.c);
    it0_d.rem   = s2_q.sq;
    it0_d.root  = '0;
    it0_d.s     = s2_q.sq;
    it0_d.e1    = $signed({39'b0, s2_q.d1sq} << 30) - $signed({38'b0, s2_q.sq});
    it0_d.e2    = $signed({39'b0, s2_q.d2sq} << 30) - $signed({38'b0, s2_q.sq});
    it0_d.p1    = -$signed({38'b0, s2_q.sq});
    it0_d.p2    = -$signed({38'b0, s2_q.sq});
    it0_d.q1    = '0;
    it0_d.q2    = '0;
    it0_d.neg1  = s2_q.neg1;
    it0_d.neg2  = s2_q.neg2;
    it0_d.z1    = s2_q.z1;
    it0_d.z2    = s2_q.z2;
  end

  // Front stage registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q    <= 1'b0;
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      it_v_q[0] <= 1'b0;
    end else if (en) begin
      s0_v_q    <= in_valid_i;
      s1_v_q    <= s0_v_q;
      s2_v_q    <= s1_v_q;
      it_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s0_q    <= s0_d;
      s1_q    <= s1_d;
      s2_q    <= s2_d;
      it_q[0] <= it0_d;
    end
  end

  // Iteration stages: one root bit per stage, plus one bit of each normal
  // magnitude in the first stages. The normal lanes keep the residual
  // E = D - w*w*s and the step term P = w*s with w = 2q-1, so each trial of
  // (w + 2^(b+1))^2 * s against D is a shift-and-subtract.
  for (genvar k = 0; k < RB; k++) begin : g_iter
    localparam int unsigned BR = RB - 1 - k;
    acpq_pkg::it_t nx_d;
    logic [69:0]   trial;

    always_comb begin
      nx_d  = it_q[k];
      trial = ({36'b0, it_q[k].root} << (BR + 1)) + (70'd1 << (2 * BR));
      if (trial <= {4'b0, it_q[k].rem}) begin
        nx_d.rem      = it_q[k].rem - trial[65:0];
        nx_d.root[BR] = 1'b1;
      end
    end

    if (k < NB) begin : g_norm
      localparam int unsigned BN = NB - 1 - k;
      acpq_pkg::it_t nn_d;
      logic signed [AW-1:0] sx;
      logic signed [AW-1:0] t1;
      logic signed [AW-1:0] t2;

      always_comb begin
        nn_d = nx_d;
        sx   = $signed({38'b0, it_q[k].s});
        t1   = it_q[k].e1 - (it_q[k].p1 <<< (BN + 2)) - (sx <<< (2 * BN + 2));
        t2   = it_q[k].e2 - (it_q[k].p2 <<< (BN + 2)) - (sx <<< (2 * BN + 2));
        if (!t1[AW-1]) begin
          nn_d.e1     = t1;
          nn_d.p1     = it_q[k].p1 + (sx <<< (BN + 1));
          nn_d.q1[BN] = 1'b1;
        end
        if (!t2[AW-1]) begin
          nn_d.e2     = t2;
          nn_d.p2     = it_q[k].p2 + (sx <<< (BN + 1));
          nn_d.q2[BN] = 1'b1;
        end
      end

      always_ff @(posedge clk_i) begin
        if (en) begin
          it_q[k+1] <= nn_d;
        end
      end
    end else begin : g_root
      always_ff @(posedge clk_i) begin
        if (en) begin
          it_q[k+1] <= nx_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        it_v_q[k+1] <= 1'b0;
      end else if (en) begin
        it_v_q[k+1] <= it_v_q[k];
      end
    end
  end

  // Final assembly: distance, normal signs and axis placement.
  acpq_pkg::it_t      last;
  acpq_pkg::res_t     fin;
  logic signed [35:0] rdist;
  logic signed [15:0] n1, n2;

  assign last = it_q[RB];

  always_comb begin
    rdist = $signed({2'b0, last.root}) - $signed({5'b0, radius_q});
    if (!sense_q) begin
      rdist = -rdist;
    end
    if (rdist > 36'sh0_7FFF_FFFF) begin
      fin.sdist = 32'sh7FFF_FFFF;
    end else if (rdist < -36'sh0_8000_0000) begin
      fin.sdist = 32'sh8000_0000;
    end else begin
      fin.sdist = rdist[31:0];
    end
    // A point on the axis has no normal.
    if (last.z1) begin
      n1 = '0;
    end else if (last.neg1 ^ sense_q) begin
      n1 = -$signed({1'b0, last.q1});
    end else begin
      n1 = $signed({1'b0, last.q1});
    end
    if (last.z2) begin
      n2 = '0;
    end else if (last.neg2 ^ sense_q) begin
      n2 = -$signed({1'b0, last.q2});
    end else begin
      n2 = $signed({1'b0, last.q2});
    end
    case (axis_q)
      acpq_pkg::AXIS_X: begin
        fin.nx = '0; fin.ny = n1; fin.nz = n2;
      end
      acpq_pkg::AXIS_Y: begin
        fin.nx = n1; fin.ny = '0; fin.nz = n2;
      end
      default: begin
        fin.nx = n1; fin.ny = n2; fin.nz = '0;
      end
    endcase
    fin.cls = last.cls;
    fin.a   = last.a_sat;
    fin.b   = last.b_sat;
    fin.c   = last.c_sat;
  end

  // Output register with one skid entry behind it.
  acpq_pkg::res_t out_q, skid_q;
  logic           out_valid_q;
  logic           take;

  assign take = out_valid_q & ~out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (it_v_q[RB]) begin
      if (!out_valid_q || take) begin
        out_valid_q <= 1'b1;
      end else begin
        skid_valid_q <= 1'b1;
      end
    end else if (take) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (take) begin
        out_q <= skid_q;
      end
    end else if (it_v_q[RB]) begin
      if (!out_valid_q || take) begin
        out_q <= fin;
      end else begin
        skid_q <= fin;
      end
    end
  end

  assign out_valid_o       = out_valid_q;
  assign inside_class_o    = out_q.cls;
  assign signed_distance_o = out_q.sdist;
  assign quad_a_o          = out_q.a;
  assign quad_b_o          = out_q.b;
  assign quad_c_o          = out_q.c;
  assign normal_x_o        = out_q.nx;
  assign normal_y_o        = out_q.ny;
  assign normal_z_o        = out_q.nz;

endmodule

@@ hw/rtl/acpq_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Axis cylinder point query checker
// Port-level checks of the query block, attached to the top level by bind.
// ----------------------------------------------------------------------------
module acpq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [1:0]         inside_class_o,
  input logic signed [63:0] quad_c_o,
  input logic signed [15:0] normal_x_o,
  input logic signed [15:0] normal_y_o,
  input logic signed [15:0] normal_z_o
);

  // A stalled result stays valid with its class and quad_c unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(quad_c_o)
      && $stable(inside_class_o))
    else $error("stalled result changed");

  // Requests are held back only while a result is waiting at the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("request stall without a pending result");

  // At least one normal component is zero, as the axial one must be.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o == 16'sd0) || (normal_y_o == 16'sd0)
      || (normal_z_o == 16'sd0))
    else $error("normal has no zero axial component");

  // Normal components stay within unit length.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (normal_x_o <= 16'sd16384) && (normal_x_o >= -16'sd16384)
      && (normal_y_o <= 16'sd16384) && (normal_y_o >= -16'sd16384)
      && (normal_z_o <= 16'sd16384) && (normal_z_o >= -16'sd16384))
    else $error("normal component out of range");

endmodule

bind axis_cylinder_point_query acpq_checker u_acpq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .inside_class_o (inside_class_o),
  .quad_c_o       (quad_c_o),
  .normal_x_o     (normal_x_o),
  .normal_y_o     (normal_y_o),
  .normal_z_o     (normal_z_o)
);
